// File: sv/msc_pkg.sv
// Shared types, constants and register codes for the solenoid compensation core.
package msc_pkg;

  localparam int COIL_MAX        = 4;
  localparam int COIL_COUNT_DEF  = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int WEIGHT_W   = 9;
  localparam int LIMIT_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int FV_W       = 24;
  localparam int EST_W      = 34;
  localparam int DIFF_W     = 25;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd51;
  localparam logic [WEIGHT_W-1:0] ALPHA_ONE  = 9'd256;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 6'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS,
    REG_GAIN0,
    REG_GAIN1,
    REG_GAIN2,
    REG_GAIN3,
    REG_WEIGHT,
    REG_LIMIT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_COMP,
    BK_FILT,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic               read_ok;
    logic signed [15:0] current_0;
    logic signed [15:0] current_1;
    logic signed [15:0] current_2;
    logic signed [15:0] current_3;
  } msc_in_t;

  typedef struct packed {
    logic    bus_reset;
    msc_in_t item;
  } msc_mid_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               out_valid;
    logic               bus_reset;
  } msc_out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] bias;
    logic [WEIGHT_W-1:0]   alpha;
    logic [LIMIT_W-1:0]    limit;
  } msc_cfg_t;

endpackage

// File: sv/magnetometer_solenoid_compensation_core.sv
// Top level: configuration registers, front end, work queue, back end, result queue.
//
// Input channel: present a reading on in_item and raise in_push; it is taken
// at a clock edge where in_full is low. Result channel: while out_empty is
// low the oldest result is on out_item; raise out_pop to take it.
// Configuration: cfg_we with cfg_index and cfg_data writes one register;
// write only while no item is in flight.
// The front end takes one item per cycle into a two-entry work queue, unless
// it is full, and updates the freeze counter at once. The back end shares one
// 25x17 multiplier: per axis one multiply-accumulate per solenoid, then a
// compensation step and a filter step; it then posts the result once the
// result queue has room. A failed reading goes straight to posting. The back
// end takes the next item only after it has posted the last one.
// Reset (synchronous, rst_n low) empties both queues, clears filter state,
// last reading and freeze count, and loads register defaults.
// A stalled receiver fills the two-entry result queue, then the work queue,
// and then in_full rises; no item is dropped.
module magnetometer_solenoid_compensation_core import msc_pkg::*; #(
  parameter int COIL_COUNT  = COIL_COUNT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  msc_in_t               in_item,
  output logic                  in_full,
  output logic                  out_empty,
  output msc_out_t              out_item,
  input  logic                  out_pop,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0]                 bias_r;
  logic [COIL_COUNT-1:0][CFG_DATA_W-1:0] gain_r;
  logic [WEIGHT_W-1:0]                   weight_r;
  logic [LIMIT_W-1:0]                    limit_r;
  msc_cfg_t                              cfg;

  logic     mid_push, mid_full, mid_pop, mid_empty;
  msc_mid_t mid_wr, mid_rd;
  logic     res_push, res_full;
  msc_out_t res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r   <= '0;
      gain_r   <= '0;
      weight_r <= WEIGHT_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIAS:   bias_r   <= cfg_data;
        REG_WEIGHT: weight_r <= cfg_data[WEIGHT_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
        default: begin
          for (int k = 0; k < COIL_COUNT; k++) begin
            if (cfg_index == CFG_IDX_W'(int'(REG_GAIN0) + k)) begin
              gain_r[k] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    cfg.bias  = bias_r;
    cfg.alpha = (weight_r > ALPHA_ONE) ? ALPHA_ONE : weight_r;
    cfg.limit = limit_r;
  end

  assign in_full = mid_full;

  msc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .limit    (cfg.limit),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wr)
  );

  msc_fifo #(.W($bits(msc_mid_t)), .DEPTH(2)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  msc_back #(.COIL_COUNT(COIL_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .gain      (gain_r),
    .mid_empty (mid_empty),
    .mid_data  (mid_rd),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  msc_fifo #(.W($bits(msc_out_t)), .DEPTH(2)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

// File: sv/msc_fifo.sv
// Small register queue used between the pipeline parts and at the result side.
module msc_fifo import msc_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: sv/msc_front.sv
// Front end: accepts readings, narrows samples, runs the freeze counter.
module msc_front import msc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  msc_in_t            in_item,
  input  logic [LIMIT_W-1:0] limit,
  input  logic               mid_full,
  output logic               mid_push,
  output msc_mid_t           mid_data
);

  logic [SAMPLE_BITS-1:0] last_raw_r [3];
  logic [COUNT_W-1:0]     stuck_cnt_r, stuck_cnt_nxt;
  logic [COUNT_W-1:0]     count_sum;
  logic                   accept;
  logic                   same_raw;
  logic                   fire;

  assign accept   = in_push && !mid_full;
  assign mid_push = accept;

  assign same_raw = (in_item.field_x[SAMPLE_BITS-1:0] == last_raw_r[0]) &&
                    (in_item.field_y[SAMPLE_BITS-1:0] == last_raw_r[1]) &&
                    (in_item.field_z[SAMPLE_BITS-1:0] == last_raw_r[2]);

  assign count_sum = stuck_cnt_r + COUNT_W'(!in_item.read_ok) + COUNT_W'(same_raw);
  assign fire      = (count_sum >= COUNT_W'(limit));
  assign stuck_cnt_nxt = fire ? '0 : count_sum;

  always_comb begin
    mid_data           = '0;
    mid_data.item      = in_item;
    mid_data.bus_reset = fire;
    mid_data.item.field_x = 16'($signed(in_item.field_x[SAMPLE_BITS-1:0]));
    mid_data.item.field_y = 16'($signed(in_item.field_y[SAMPLE_BITS-1:0]));
    mid_data.item.field_z = 16'($signed(in_item.field_z[SAMPLE_BITS-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stuck_cnt_r   <= '0;
      last_raw_r[0] <= '0;
      last_raw_r[1] <= '0;
      last_raw_r[2] <= '0;
    end else if (accept) begin
      stuck_cnt_r <= stuck_cnt_nxt;
      if (in_item.read_ok) begin
        last_raw_r[0] <= in_item.field_x[SAMPLE_BITS-1:0];
        last_raw_r[1] <= in_item.field_y[SAMPLE_BITS-1:0];
        last_raw_r[2] <= in_item.field_z[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

// File: sv/msc_back.sv
// Back end: shared-multiplier compensation and low-pass filter sequencer.
module msc_back import msc_pkg::*; #(
  parameter int COIL_COUNT = COIL_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  msc_cfg_t                             cfg,
  input  logic [COIL_COUNT-1:0][CFG_DATA_W-1:0] gain,
  input  logic                                 mid_empty,
  input  msc_mid_t                             mid_data,
  output logic                                 mid_pop,
  input  logic                                 res_full,
  output logic                                 res_push,
  output msc_out_t                             res_data
);

  localparam int CW = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  back_state_t              state_r, state_nxt;
  logic [CW-1:0]            coil_r;
  logic [1:0]               axis_r;
  logic signed [EST_W-1:0]  acc_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [FV_W-1:0]   fv_r [3];

  msc_in_t                  head;
  logic signed [15:0]       cur [COIL_MAX];
  logic signed [15:0]       raw_a, bias_a, gain_a;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [EST_W-1:0]  est_rnd;
  logic signed [19:0]       est_sh;
  logic signed [21:0]       comp_wide;
  logic signed [15:0]       comp;
  logic signed [FV_W-1:0]   comp_q;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [FV_W-1:0]   fv_cur, fv_nxt;
  logic signed [FV_W:0]     out_rnd [3];
  logic                     last_coil;

  assign head   = mid_data.item;
  assign cur[0] = head.current_0;
  assign cur[1] = head.current_1;
  assign cur[2] = head.current_2;
  assign cur[3] = head.current_3;

  always_comb begin
    case (axis_r)
      2'd0:    raw_a = head.field_x;
      2'd1:    raw_a = head.field_y;
      default: raw_a = head.field_z;
    endcase
  end

  assign bias_a    = cfg.bias[{axis_r, 4'b0} +: 16];
  assign gain_a    = gain[coil_r][{axis_r, 4'b0} +: 16];
  assign last_coil = (coil_r == CW'(COIL_COUNT - 1));
  assign fv_cur    = fv_r[axis_r];

  always_comb begin
    if (state_r == BK_FILT) begin
      mul_a = diff_r;
      mul_b = $signed({8'b0, cfg.alpha});
    end else begin
      mul_a = MUL_A_W'(gain_a);
      mul_b = MUL_B_W'(cur[2'(coil_r)]);
    end
  end

  assign prod      = mul_a * mul_b;
  assign est_rnd   = acc_r + EST_W'(8192);
  assign est_sh    = est_rnd[EST_W-1:14];
  assign comp_wide = 22'(raw_a) - 22'(bias_a) - 22'(est_sh);
  assign comp      = sat16(comp_wide);
  assign comp_q    = {comp, 8'b0};
  assign diff_nxt  = DIFF_W'(comp_q) - DIFF_W'(fv_cur);
  assign fv_nxt    = fv_cur + $signed(prod[31:8]);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      out_rnd[a] = (25'(fv_r[a]) + 25'sd128) >>> 8;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!mid_empty) begin
          state_nxt = head.read_ok ? BK_MAC : BK_DONE;
        end
      end
      BK_MAC: begin
        if (last_coil) begin
          state_nxt = BK_COMP;
        end
      end
      BK_COMP: state_nxt = BK_FILT;
      BK_FILT: state_nxt = (axis_r == 2'd2) ? BK_DONE : BK_MAC;
      BK_DONE: begin
        if (!res_full) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    res_push = 1'b0;
    mid_pop  = 1'b0;
    res_data = '0;
    case (state_r)
      BK_DONE: begin
        res_push = !res_full;
        mid_pop  = !res_full;
      end
      default: begin
        res_push = 1'b0;
        mid_pop  = 1'b0;
      end
    endcase
    res_data.out_valid = head.read_ok;
    res_data.bus_reset = mid_data.bus_reset;
    if (head.read_ok) begin
      res_data.out_x = sat16(22'($signed(out_rnd[0][FV_W-8:0])));
      res_data.out_y = sat16(22'($signed(out_rnd[1][FV_W-8:0])));
      res_data.out_z = sat16(22'($signed(out_rnd[2][FV_W-8:0])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      fv_r[0] <= '0;
      fv_r[1] <= '0;
      fv_r[2] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_FILT) begin
        fv_r[axis_r] <= fv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        coil_r <= '0;
        axis_r <= '0;
        acc_r  <= '0;
      end
      BK_MAC: begin
        acc_r  <= acc_r + prod[EST_W-1:0];
        coil_r <= last_coil ? '0 : coil_r + 1'b1;
      end
      BK_COMP: diff_r <= diff_nxt;
      BK_FILT: begin
        axis_r <= axis_r + 1'b1;
        acc_r  <= '0;
      end
      default: acc_r <= acc_r;
    endcase
  end

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> !mid_empty)
    else $error("back end lost its queue head while working");

  a_work_on_good_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MAC || state_r == BK_COMP || state_r == BK_FILT) |-> head.read_ok)
    else $error("filter update on a failed read");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MAC || state_r == BK_COMP || state_r == BK_FILT) |-> axis_r != 2'd3)
    else $error("axis counter out of range");

  a_pop_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |=> state_r == BK_IDLE)
    else $error("queue popped without returning to idle");

endmodule

// File: bench/msc_compensation_checker.sv
// Channel monitor for the compensation core: predicts every filtered reading and compares.
`timescale 1ns / 100ps
module msc_compensation_checker import msc_pkg::*; #(
  parameter int COIL_COUNT  = COIL_COUNT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  msc_in_t               in_item,
  input  logic                  in_full,
  input  logic                  out_empty,
  input  msc_out_t              out_item,
  input  logic                  out_pop,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    backlog,
  output int                    checked,
  output int                    bus_resets
);

  logic [CFG_DATA_W-1:0]  bias_lanes;
  logic [CFG_DATA_W-1:0]  gain_lanes [COIL_MAX];
  logic [WEIGHT_W-1:0]    weight;
  logic [LIMIT_W-1:0]     freeze_limit;
  logic signed [15:0]     last_good [3];
  logic [COUNT_W-1:0]     stuck_count;
  logic signed [FV_W-1:0] smoothed [3];
  msc_out_t               predicted_outputs [$];

  function automatic longint lane(logic [CFG_DATA_W-1:0] word, int axis);
    return longint'($signed(word[16*axis +: 16]));
  endfunction

  function automatic longint sample_of(logic [15:0] field);
    longint v;
    v = longint'($signed(field));
    return (v <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic msc_out_t compensate_reading(msc_in_t rd);
    msc_out_t           res;
    longint             raw [3];
    longint             amps [COIL_MAX];
    longint             filtered [3];
    longint             alpha;
    longint             est;
    longint             comp;
    longint             diff;
    longint             acc;
    logic [COUNT_W-1:0] count;
    raw[0]  = sample_of(rd.field_x);
    raw[1]  = sample_of(rd.field_y);
    raw[2]  = sample_of(rd.field_z);
    amps[0] = longint'(rd.current_0);
    amps[1] = longint'(rd.current_1);
    amps[2] = longint'(rd.current_2);
    amps[3] = longint'(rd.current_3);
    alpha   = (weight > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(weight);
    res     = '0;

    count = stuck_count;
    if (!rd.read_ok) count = count + 1'b1;
    if (raw[0] == last_good[0] && raw[1] == last_good[1] && raw[2] == last_good[2]) begin
      count = count + 1'b1;
    end
    if (count >= COUNT_W'(freeze_limit)) begin
      res.bus_reset = 1'b1;
      count = '0;
    end
    stuck_count = count;

    if (rd.read_ok) begin
      for (int a = 0; a < 3; a++) begin
        last_good[a] = raw[a][15:0];
        est = 0;
        for (int i = 0; i < COIL_COUNT && i < COIL_MAX; i++) begin
          est += lane(gain_lanes[i], a) * amps[i];
        end
        comp = clamp16(raw[a] - lane(bias_lanes, a) - ((est + 8192) >>> 14));
        diff = comp * 256 - longint'(smoothed[a]);
        acc = longint'(smoothed[a]) + ((alpha * diff) >>> 8);
        smoothed[a] = acc[FV_W-1:0];
        filtered[a] = clamp16((longint'(smoothed[a]) + 128) >>> 8);
      end
      res.out_x     = filtered[0][15:0];
      res.out_y     = filtered[1][15:0];
      res.out_z     = filtered[2][15:0];
      res.out_valid = 1'b1;
    end
    return res;
  endfunction

  task automatic compare_field(string name, logic signed [16:0] want, logic signed [16:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
               $time, name, checked, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    msc_out_t want;
    if (!rst_n) begin
      bias_lanes   = '0;
      gain_lanes   = '{default: '0};
      weight       = WEIGHT_RST;
      freeze_limit = LIMIT_RST;
      last_good    = '{default: '0};
      stuck_count  = '0;
      smoothed     = '{default: '0};
      predicted_outputs.delete();
      fail_count   = 0;
      checked      = 0;
      bus_resets   = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (predicted_outputs.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result x=%0d y=%0d z=%0d valid=%0b bus_reset=%0b",
                   $time, out_item.out_x, out_item.out_y, out_item.out_z,
                   out_item.out_valid, out_item.bus_reset);
        end else begin
          want = predicted_outputs.pop_front();
          compare_field("out_x", 17'(want.out_x), 17'(out_item.out_x));
          compare_field("out_y", 17'(want.out_y), 17'(out_item.out_y));
          compare_field("out_z", 17'(want.out_z), 17'(out_item.out_z));
          compare_field("out_valid", 17'(want.out_valid), 17'(out_item.out_valid));
          compare_field("bus_reset", 17'(want.bus_reset), 17'(out_item.bus_reset));
        end
        checked++;
      end
      if (in_push && !in_full) begin
        want = compensate_reading(in_item);
        if (want.bus_reset) bus_resets++;
        predicted_outputs.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BIAS:   bias_lanes    = cfg_data;
          REG_GAIN0:  gain_lanes[0] = cfg_data;
          REG_GAIN1:  gain_lanes[1] = cfg_data;
          REG_GAIN2:  gain_lanes[2] = cfg_data;
          REG_GAIN3:  gain_lanes[3] = cfg_data;
          REG_WEIGHT: weight        = cfg_data[WEIGHT_W-1:0];
          REG_LIMIT:  freeze_limit  = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    backlog = predicted_outputs.size();
  end

endmodule

// File: bench/magnetometer_solenoid_compensation_core_tb.sv
// Stimulus, register setup and verdict for the solenoid compensation core.
`timescale 1ns / 100ps
module magnetometer_solenoid_compensation_core_tb;
  import msc_pkg::*;

  localparam int READINGS_PER_PHASE = 147;
  localparam int PHASES             = 8;
  localparam int STALL_LIMIT        = 4000;
  localparam int HOLD_CYCLES        = 400;
  localparam int HOLD_AT            = 700;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  msc_in_t               in_item;
  logic                  in_full;
  logic                  out_empty;
  msc_out_t              out_item;
  logic                  out_pop;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int      fail_count;
  int      backlog;
  int      checked;
  int      bus_resets;
  int      sent;
  int      failed_reads;
  int      settings;
  int      idle_cycles;
  bit      steady;
  bit      hold_now;
  bit      hold_done;
  msc_in_t last_good;

  magnetometer_solenoid_compensation_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  msc_compensation_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_item    (in_item),
    .in_full    (in_full),
    .out_empty  (out_empty),
    .out_item   (out_item),
    .out_pop    (out_pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .backlog    (backlog),
    .checked    (checked),
    .bus_resets (bus_resets)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [15:0] pick_field(logic signed [15:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom);
    if (r < 12) return 16'sh7fff;
    if (r < 14) return 16'sh8000;
    return base + 16'(int'($urandom_range(0, 800)) - 400);
  endfunction

  function automatic logic signed [15:0] pick_current();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom);
    if (r < 11) return 16'sd16384;
    if (r < 14) return -16'sd16384;
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_lanes(int span);
    logic [CFG_DATA_W-1:0] word;
    for (int a = 0; a < 3; a++) begin
      word[16*a +: 16] = (span > 32767) ? 16'($urandom)
                                        : 16'(int'($urandom_range(0, 2 * span)) - span);
    end
    return word;
  endfunction

  function automatic msc_in_t make_reading(
    logic signed [15:0] fx, logic signed [15:0] fy, logic signed [15:0] fz, logic ok,
    logic signed [15:0] c0, logic signed [15:0] c1, logic signed [15:0] c2,
    logic signed [15:0] c3);
    msc_in_t rd;
    rd.field_x   = fx;
    rd.field_y   = fy;
    rd.field_z   = fz;
    rd.read_ok   = ok;
    rd.current_0 = c0;
    rd.current_1 = c1;
    rd.current_2 = c2;
    rd.current_3 = c3;
    return rd;
  endfunction

  task automatic send_reading(msc_in_t rd);
    int gap;
    in_item = rd;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    sent++;
    if (sent == HOLD_AT) hold_now = 1'b1;
    if (!rd.read_ok) failed_reads++;
    else last_good = rd;
    @(negedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic wait_drained();
    in_push = 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int gap;
    out_pop = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_now && !hold_done) begin
        hold_done = 1'b1;
        out_pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_pop = 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] word;
    logic [WEIGHT_W-1:0]   weight;
    logic [LIMIT_W-1:0]    limit;
    msc_in_t               rd;
    int                    roll;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_BIAS;
    cfg_data     = '0;
    steady       = 1'b0;
    hold_now     = 1'b0;
    hold_done    = 1'b0;
    idle_cycles  = 0;
    sent         = 0;
    failed_reads = 0;
    settings     = 1;
    last_good    = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset defaults: zero gains, default weight and freeze limit
    send_reading(make_reading('0, '0, '0, 1'b1, '0, '0, '0, '0));
    send_reading(make_reading(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1,
                              16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384));
    send_reading(make_reading(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1,
                              16'sh8000, 16'sh7fff, -16'sd1, 16'sd1));
    send_reading(make_reading(16'sd1234, -16'sd5, 16'sd77, 1'b0,
                              16'sd100, -16'sd100, '0, '0));
    // stuck sensor with failed reads: two counts per item until the limit fires
    repeat (9) send_reading(make_reading(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0,
                                         '0, '0, '0, '0));

    wait_drained();
    write_reg(REG_BIAS, {16'h8000, 16'h7fff, 16'h8000});
    write_reg(REG_GAIN0, {16'h7fff, 16'h7fff, 16'h7fff});
    write_reg(REG_GAIN1, {16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_GAIN2, {16'h7fff, 16'h8000, 16'h0001});
    write_reg(REG_GAIN3, {16'hffff, 16'h0000, 16'h8000});
    write_reg(REG_WEIGHT, CFG_DATA_W'(ALPHA_ONE));
    write_reg(REG_LIMIT, 48'd1);
    write_reg(REG_SPARE, 48'hffff_ffff_ffff);
    settings++;
    send_reading(make_reading(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1,
                              16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384));
    send_reading(make_reading(16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
                              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    send_reading(make_reading(16'sh8000, 16'sh7fff, '0, 1'b1,
                              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_reading(make_reading('0, '0, '0, 1'b1, '0, '0, '0, '0));
    send_reading(make_reading('0, '0, '0, 1'b1, '0, '0, '0, '0));
    send_reading(make_reading(16'sd5, 16'sd6, 16'sd7, 1'b0, '0, '0, '0, '0));
    send_reading(make_reading(16'sh7fff, 16'sh8000, '0, 1'b1,
                              16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      steady = (p % 3 == 1);
      case (p)
        0: begin weight = 9'd51;  limit = 6'd20; end
        1: begin weight = 9'd0;   limit = 6'd1;  end
        2: begin weight = 9'd256; limit = 6'd63; end
        3: begin weight = 9'd511; limit = 6'd0;  end
        4: begin weight = 9'd1;   limit = 6'd5;  end
        5: begin weight = 9'd300; limit = 6'd2;  end
        6: begin weight = 9'd128; limit = 6'd40; end
        default: begin
          weight = 9'($urandom);
          limit  = 6'($urandom);
        end
      endcase
      write_reg(REG_BIAS, pick_lanes((p % 2) ? 32768 : 2000));
      write_reg(REG_GAIN0, pick_lanes((p % 2) ? 32768 : 3000));
      write_reg(REG_GAIN1, pick_lanes((p % 2) ? 32768 : 3000));
      write_reg(REG_GAIN2, pick_lanes((p % 2) ? 32768 : 3000));
      write_reg(REG_GAIN3, pick_lanes((p % 2) ? 32768 : 3000));
      word = CFG_DATA_W'({$urandom, $urandom});
      word[WEIGHT_W-1:0] = weight;
      write_reg(REG_WEIGHT, word);
      word = CFG_DATA_W'({$urandom, $urandom});
      word[LIMIT_W-1:0] = limit;
      write_reg(REG_LIMIT, word);
      write_reg(REG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
      settings++;

      for (int k = 0; k < READINGS_PER_PHASE; k++) begin
        roll = $urandom_range(0, 99);
        rd = make_reading(pick_field(last_good.field_x), pick_field(last_good.field_y),
                          pick_field(last_good.field_z), 1'b1, pick_current(),
                          pick_current(), pick_current(), pick_current());
        if (roll < 8) begin
          rd.field_x = last_good.field_x;
          rd.field_y = last_good.field_y;
          rd.field_z = last_good.field_z;
        end else if (roll < 16) begin
          rd.read_ok = 1'b0;
        end else if (roll < 22) begin
          rd.read_ok = 1'b0;
          rd.field_x = last_good.field_x;
          rd.field_y = last_good.field_y;
          rd.field_z = last_good.field_z;
        end
        send_reading(rd);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Run drove %0d readings (%0d failed reads) through %0d register settings.",
             sent, failed_reads, settings);
    $display("Compared %0d results, %0d of them with a predicted bus reset pulse.",
             checked, bus_resets);
    if (fail_count == 0 && backlog == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
